>>> rtl/stodc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stodc_pkg
// Shared types and constants for the settable time-of-day clock: item and
// result layouts, frame codes, field limits and reset values.
// ----------------------------------------------------------------------------
package stodc_pkg;

	// frame codes
	localparam logic [7:0] FRAME_SYNC = 8'hAA;
	localparam logic [7:0] MODE_EDIT  = 8'd1;
	localparam logic [7:0] BTN_UP     = 8'd0;
	localparam logic [7:0] BTN_DOWN   = 8'd1;
	localparam logic [7:0] BTN_LEFT   = 8'd2;
	localparam logic [7:0] BTN_RIGHT  = 8'd3;

	// item kinds
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_FRAME = 1'b1;

	// cursor codes
	localparam logic [1:0] CUR_HOURS   = 2'd0;
	localparam logic [1:0] CUR_MINUTES = 2'd1;
	localparam logic [1:0] CUR_SECONDS = 2'd2;
	localparam logic [1:0] CUR_UNUSED  = 2'd3;

	// field limits and reset values
	localparam logic [4:0] HOURS_TOP    = 5'd23;
	localparam logic [5:0] MINUTES_TOP  = 6'd59;
	localparam logic [5:0] SECONDS_TOP  = 6'd59;
	localparam logic [4:0] HOURS_RST    = 5'd17;
	localparam logic [5:0] MINUTES_RST  = 6'd15;
	localparam logic [5:0] SECONDS_RST  = 6'd0;
	localparam logic [7:0] TPS_RST      = 8'd40;

	localparam logic [5:0] ASCII_ZERO   = 6'd48;

	typedef struct packed {
		logic       cmd;
		logic [7:0] frame_header;
		logic [7:0] frame_mode;
		logic [7:0] frame_button;
		logic [7:0] frame_check;
	} cmd_t;

	typedef struct packed {
		logic [5:0] hours_tens_char;
		logic [5:0] hours_ones_char;
		logic [5:0] minutes_tens_char;
		logic [5:0] minutes_ones_char;
		logic [5:0] seconds_tens_char;
		logic [5:0] seconds_ones_char;
		logic [1:0] cursor_field;
		logic       edit_active;
		logic       clear_pulse;
		logic       refresh_pulse;
		logic       frame_accepted;
	} res_t;

	// binary result of one update, before digit conversion
	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [1:0] cursor;
		logic       edit;
		logic       clear;
		logic       refresh;
		logic       accepted;
	} core_out_t;

endpackage : stodc_pkg
`default_nettype wire

>>> rtl/stodc_cmd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stodc_cmd_if
// Input channel: valid/ready handshake carrying one tick or command frame.
// ----------------------------------------------------------------------------
interface stodc_cmd_if;
	import stodc_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface : stodc_cmd_if
`default_nettype wire

>>> rtl/stodc_res_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stodc_res_if
// Result channel: valid/ready handshake carrying one display result.
// ----------------------------------------------------------------------------
interface stodc_res_if;
	import stodc_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);

endinterface : stodc_res_if
`default_nettype wire

>>> rtl/stodc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stodc_core
// Clock state and its combinational update: tick counting with clear and
// advance, frame check, edit mode and button actions.
// ----------------------------------------------------------------------------
module stodc_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire stodc_pkg::cmd_t    item,
	input  wire logic [7:0]         tps,
	output stodc_pkg::core_out_t    result
);
	import stodc_pkg::*;

	logic [4:0] hour_q;
	logic [5:0] minute_q;
	logic [5:0] second_q;
	logic [7:0] tick_q;
	logic [1:0] cursor_q;
	logic       edit_q;

	logic [4:0] hour_d;
	logic [5:0] minute_d;
	logic [5:0] second_d;
	logic [7:0] tick_d;
	logic [1:0] cursor_d;
	logic       edit_d;
	logic       clear;
	logic       refresh;
	logic       accepted;

	logic [7:0] tick_inc;
	logic [7:0] expect_chk;
	logic [4:0] hour_up;
	logic [4:0] hour_dn;
	logic [5:0] minute_up;
	logic [5:0] minute_dn;
	logic [5:0] second_up;
	logic [5:0] second_dn;

	// wrap steps for each field
	assign hour_up   = (hour_q >= HOURS_TOP) ? 5'd0 : hour_q + 5'd1;
	assign hour_dn   = (hour_q == 5'd0 || hour_q > HOURS_TOP) ? HOURS_TOP : hour_q - 5'd1;
	assign minute_up = (minute_q >= MINUTES_TOP) ? 6'd0 : minute_q + 6'd1;
	assign minute_dn = (minute_q == 6'd0 || minute_q > MINUTES_TOP) ?
		MINUTES_TOP : minute_q - 6'd1;
	assign second_up = (second_q >= SECONDS_TOP) ? 6'd0 : second_q + 6'd1;
	assign second_dn = (second_q == 6'd0 || second_q > SECONDS_TOP) ?
		SECONDS_TOP : second_q - 6'd1;

	assign tick_inc   = tick_q + 8'd1;
	assign expect_chk = ~(item.frame_mode + item.frame_button);

	// compute next state and pulses for the item in the input register
	always_comb begin
		hour_d   = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		tick_d   = tick_q;
		cursor_d = cursor_q;
		edit_d   = edit_q;
		clear    = 1'b0;
		refresh  = 1'b0;
		accepted = 1'b0;
		if (item.cmd == CMD_TICK) begin
			tick_d = tick_inc;
			priority if (tick_inc == tps - 8'd1) begin
				clear = 1'b1;
			end else if (tick_inc == tps) begin
				tick_d   = 8'd0;
				refresh  = 1'b1;
				second_d = second_up;
				if (second_up == 6'd0) begin
					minute_d = minute_up;
					if (minute_up == 6'd0) begin
						hour_d = hour_up;
					end
				end
			end
		end else if (item.frame_header == FRAME_SYNC &&
				item.frame_check == expect_chk) begin
			accepted = 1'b1;
			edit_d   = (item.frame_mode == MODE_EDIT);
			if (item.frame_mode == MODE_EDIT) begin
				refresh = 1'b1;
				if (cursor_q != CUR_UNUSED) begin
					unique case (item.frame_button)
						BTN_UP: begin
							unique case (cursor_q)
								CUR_HOURS:   hour_d   = hour_up;
								CUR_MINUTES: minute_d = minute_up;
								default:     second_d = second_up;
							endcase
						end
						BTN_DOWN: begin
							unique case (cursor_q)
								CUR_HOURS:   hour_d   = hour_dn;
								CUR_MINUTES: minute_d = minute_dn;
								default:     second_d = second_dn;
							endcase
						end
						BTN_LEFT:  cursor_d = (cursor_q == CUR_HOURS) ?
							CUR_SECONDS : cursor_q - 2'd1;
						BTN_RIGHT: cursor_d = (cursor_q == CUR_SECONDS) ?
							CUR_HOURS : cursor_q + 2'd1;
						default: ;
					endcase
				end
			end
		end
	end

	// hold state, advance on each processed transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hour_q   <= HOURS_RST;
			minute_q <= MINUTES_RST;
			second_q <= SECONDS_RST;
			tick_q   <= 8'd0;
			cursor_q <= CUR_HOURS;
			edit_q   <= 1'b0;
		end else if (fire) begin
			hour_q   <= hour_d;
			minute_q <= minute_d;
			second_q <= second_d;
			tick_q   <= tick_d;
			cursor_q <= cursor_d;
			edit_q   <= edit_d;
		end
	end

	assign result.hours    = hour_d;
	assign result.minutes  = minute_d;
	assign result.seconds  = second_d;
	assign result.cursor   = cursor_d;
	assign result.edit     = edit_d;
	assign result.clear    = clear;
	assign result.refresh  = refresh;
	assign result.accepted = accepted;

endmodule : stodc_core
`default_nettype wire

>>> rtl/stodc_digits.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stodc_digits
// Split binary time fields into tens and ones and form ASCII characters.
// ----------------------------------------------------------------------------
module stodc_digits (
	input  wire stodc_pkg::core_out_t core,
	output stodc_pkg::res_t           res
);
	import stodc_pkg::*;

	// tens digit of a value below 64 by a compare chain
	function automatic logic [2:0] tens_of(input logic [5:0] v);
		logic [2:0] t;
		priority if (v >= 6'd60) t = 3'd6;
		else if (v >= 6'd50) t = 3'd5;
		else if (v >= 6'd40) t = 3'd4;
		else if (v >= 6'd30) t = 3'd3;
		else if (v >= 6'd20) t = 3'd2;
		else if (v >= 6'd10) t = 3'd1;
		else t = 3'd0;
		return t;
	endfunction

	function automatic logic [5:0] tens_char(input logic [5:0] v);
		return ASCII_ZERO + {3'd0, tens_of(v)};
	endfunction

	function automatic logic [5:0] ones_char(input logic [5:0] v);
		logic [5:0] tenx;
		logic [3:0] ones;
		tenx = {3'd0, tens_of(v)} * 6'd10;
		ones = 4'(v - tenx);
		return ASCII_ZERO + {2'd0, ones};
	endfunction

	logic [5:0] hours_w;

	assign hours_w = {1'b0, core.hours};

	assign res.hours_tens_char   = tens_char(hours_w);
	assign res.hours_ones_char   = ones_char(hours_w);
	assign res.minutes_tens_char = tens_char(core.minutes);
	assign res.minutes_ones_char = ones_char(core.minutes);
	assign res.seconds_tens_char = tens_char(core.seconds);
	assign res.seconds_ones_char = ones_char(core.seconds);
	assign res.cursor_field      = core.cursor;
	assign res.edit_active       = core.edit;
	assign res.clear_pulse       = core.clear;
	assign res.refresh_pulse     = core.refresh;
	assign res.frame_accepted    = core.accepted;

endmodule : stodc_digits
`default_nettype wire

>>> rtl/settable_time_of_day_clock.sv
`default_nettype none
// Accepted transactions enter the input register, then the result register once
// it is free. Throughput: one transaction per cycle while results are taken;
// the two registers form a pipeline with the state update combinational between
// them. Asynchronous active-low reset sets 17:15:00, tick count 0, cursor on
// hours, edit off, one-second period 40 ticks, both stages empty.
// ----------------------------------------------------------------------------
// settable_time_of_day_clock
// Hours:minutes:seconds clock advanced by tick transactions and edited by
// checked command frames; each transaction yields one display result.
// ----------------------------------------------------------------------------
module settable_time_of_day_clock (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	stodc_cmd_if.sink       cmd_ch,
	stodc_res_if.source     res_ch
);
	import stodc_pkg::*;

	logic [7:0] tps_val_q;
	logic      valid_s1;
	cmd_t      data_s1;
	logic      valid_s2;
	res_t      data_s2;
	logic      fire_s1;
	core_out_t core_w;
	res_t      res_w;

	// period register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_val_q <= TPS_RST;
		end else if (cfg_we) begin
			tps_val_q <= cfg_wdata;
		end
	end

	// move the input register forward when the result slot frees up
	assign fire_s1      = valid_s1 && (!valid_s2 || res_ch.ready);
	assign cmd_ch.ready = !valid_s1 || fire_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			data_s1 <= cmd_ch.data;
		end
	end

	stodc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire_s1),
		.item   (data_s1),
		.tps    (tps_val_q),
		.result (core_w)
	);

	stodc_digits u_digits (
		.core (core_w),
		.res  (res_w)
	);

	// result register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (res_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			data_s2 <= res_w;
		end
	end

	assign res_ch.valid = valid_s2;
	assign res_ch.data  = data_s2;

endmodule : settable_time_of_day_clock
`default_nettype wire

>>> verif/tb_settable_time_of_day_clock.sv
// ----------------------------------------------------------------------------
// tb_settable_time_of_day_clock
// Self-checking bench for the settable time-of-day clock. A scoreboard keeps
// its own copy of the clock, the tick counter, the cursor and the edit flag.
// It predicts the display result of every accepted tick or command frame and
// compares each returned result field by field, in order. A directed opening
// walks every button, both cursor wraps, both seconds wraps and each frame rejection. Random
// phases under several one-second periods follow, including the extremes
// and the wrapping periods 0 and 1. Both sides idle at random, and the
// receiver once stalls long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_settable_time_of_day_clock;
	timeunit 1ns;
	timeprecision 1ps;

	import stodc_pkg::*;

	localparam int PHASE_ITEMS = 165;
	localparam int NUM_PHASES  = 7;
	localparam int LONG_HOLD   = 80;
	localparam int MAX_REPORTS = 10;
	localparam int TAIL_CYCLES = 8;

	// Track the clock state and queue the display expected for each transaction.
	class clock_scoreboard;
		logic [4:0] hours      = HOURS_RST;
		logic [5:0] minutes    = MINUTES_RST;
		logic [5:0] seconds    = SECONDS_RST;
		logic [7:0] tick_count = 8'd0;
		logic [7:0] period     = TPS_RST;
		logic [1:0] cursor     = CUR_HOURS;
		logic       edit       = 1'b0;
		res_t       expected_display[$];
		int         failures   = 0;

		function int step_up(int v, int limit);
			return (v + 1 >= limit) ? 0 : v + 1;
		endfunction

		function int step_down(int v, int limit);
			return (v == 0 || v >= limit) ? limit - 1 : v - 1;
		endfunction

		// Carry seconds into minutes into hours.
		function void advance_second();
			seconds = 6'(step_up(seconds, int'(SECONDS_TOP) + 1));
			if (seconds == 6'd0) begin
				minutes = 6'(step_up(minutes, int'(MINUTES_TOP) + 1));
				if (minutes == 6'd0)
					hours = 5'(step_up(hours, int'(HOURS_TOP) + 1));
			end
		endfunction

		// Apply one button to the field under the cursor, or move the cursor.
		function void apply_button(logic [7:0] btn);
			logic [1:0] pos;
			int         lim;
			int         v;
			pos = cursor;
			case (pos)
				CUR_HOURS: begin
					lim = int'(HOURS_TOP) + 1;
					v = hours;
				end
				CUR_MINUTES: begin
					lim = int'(MINUTES_TOP) + 1;
					v = minutes;
				end
				CUR_SECONDS: begin
					lim = int'(SECONDS_TOP) + 1;
					v = seconds;
				end
				default: return;
			endcase
			case (btn)
				BTN_UP:    v = step_up(v, lim);
				BTN_DOWN:  v = step_down(v, lim);
				BTN_LEFT:  cursor = (cursor == CUR_HOURS) ? CUR_SECONDS : cursor - 2'd1;
				BTN_RIGHT: cursor = (cursor == CUR_SECONDS) ? CUR_HOURS : cursor + 2'd1;
				default: ;
			endcase
			case (pos)
				CUR_HOURS:   hours = 5'(v);
				CUR_MINUTES: minutes = 6'(v);
				default:     seconds = 6'(v);
			endcase
		endfunction

		function void set_period(logic [7:0] value);
			period = value;
		endfunction

		// Update the state for one accepted transaction and queue its display.
		function void note_item(cmd_t item);
			res_t       r;
			logic [7:0] sum;
			logic       clear;
			logic       refresh;
			logic       accepted;
			clear = 1'b0;
			refresh = 1'b0;
			accepted = 1'b0;
			if (item.cmd == CMD_TICK) begin
				// clear compare wins over the advance compare
				tick_count = tick_count + 8'd1;
				if (tick_count == period - 8'd1) begin
					clear = 1'b1;
				end else if (tick_count == period) begin
					advance_second();
					tick_count = 8'd0;
					refresh = 1'b1;
				end
			end else begin
				// checksum is taken over the truncated 8-bit sum
				sum = item.frame_mode + item.frame_button;
				if (item.frame_header == FRAME_SYNC && item.frame_check == ~sum) begin
					accepted = 1'b1;
					edit = (item.frame_mode == MODE_EDIT);
					if (edit) begin
						apply_button(item.frame_button);
						refresh = 1'b1;
					end
				end
			end
			r.hours_tens_char   = 6'(int'(hours) / 10 + int'(ASCII_ZERO));
			r.hours_ones_char   = 6'(int'(hours) % 10 + int'(ASCII_ZERO));
			r.minutes_tens_char = 6'(int'(minutes) / 10 + int'(ASCII_ZERO));
			r.minutes_ones_char = 6'(int'(minutes) % 10 + int'(ASCII_ZERO));
			r.seconds_tens_char = 6'(int'(seconds) / 10 + int'(ASCII_ZERO));
			r.seconds_ones_char = 6'(int'(seconds) % 10 + int'(ASCII_ZERO));
			r.cursor_field      = cursor;
			r.edit_active       = edit;
			r.clear_pulse       = clear;
			r.refresh_pulse     = refresh;
			r.frame_accepted    = accepted;
			expected_display.push_back(r);
		endfunction

		function string show(res_t r);
			return $sformatf("%c%c:%c%c:%c%c cur=%0d edit=%b clr=%b ref=%b acc=%b",
				r.hours_tens_char, r.hours_ones_char, r.minutes_tens_char,
				r.minutes_ones_char, r.seconds_tens_char, r.seconds_ones_char,
				r.cursor_field, r.edit_active, r.clear_pulse, r.refresh_pulse,
				r.frame_accepted);
		endfunction

		// Compare a returned result with the oldest expected display.
		function void check_result(res_t got);
			res_t  want;
			string bad;
			if (expected_display.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("unexpected result %s with nothing pending", show(got));
				return;
			end
			want = expected_display.pop_front();
			bad = "";
			if (got.hours_tens_char !== want.hours_tens_char) bad = {bad, " hours_tens"};
			if (got.hours_ones_char !== want.hours_ones_char) bad = {bad, " hours_ones"};
			if (got.minutes_tens_char !== want.minutes_tens_char) bad = {bad, " minutes_tens"};
			if (got.minutes_ones_char !== want.minutes_ones_char) bad = {bad, " minutes_ones"};
			if (got.seconds_tens_char !== want.seconds_tens_char) bad = {bad, " seconds_tens"};
			if (got.seconds_ones_char !== want.seconds_ones_char) bad = {bad, " seconds_ones"};
			if (got.cursor_field !== want.cursor_field) bad = {bad, " cursor_field"};
			if (got.edit_active !== want.edit_active) bad = {bad, " edit_active"};
			if (got.clear_pulse !== want.clear_pulse) bad = {bad, " clear_pulse"};
			if (got.refresh_pulse !== want.refresh_pulse) bad = {bad, " refresh_pulse"};
			if (got.frame_accepted !== want.frame_accepted) bad = {bad, " frame_accepted"};
			if (bad != "") begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("mismatch in%s: expected %s got %s", bad, show(want), show(got));
			end
		endfunction

		function int pending();
			return expected_display.size();
		endfunction

		function int total_failures();
			return failures + expected_display.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;
	bit no_idle = 1'b0;
	bit hold_request = 1'b0;
	clock_scoreboard board;

	stodc_cmd_if cmd_ch();
	stodc_res_if res_ch();

	settable_time_of_day_clock DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd_ch    (cmd_ch),
		.res_ch    (res_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Pick an idle length: mostly none, sometimes short, rarely long.
	function automatic int idle_cycles();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic cmd_t make_frame(logic [7:0] hdr, logic [7:0] mode, logic [7:0] btn);
		cmd_t       f;
		logic [7:0] sum;
		sum = mode + btn;
		f.cmd          = CMD_FRAME;
		f.frame_header = hdr;
		f.frame_mode   = mode;
		f.frame_button = btn;
		f.frame_check  = ~sum;
		return f;
	endfunction

	// Mostly ticks and well-formed frames, with some broken frames and noise.
	function automatic cmd_t random_item();
		cmd_t       it;
		int         pick;
		logic [7:0] mode;
		logic [7:0] btn;
		logic [7:0] flip;
		pick = $urandom_range(0, 99);
		flip = 8'($urandom_range(1, 255));
		mode = ($urandom_range(0, 9) < 8) ? MODE_EDIT : 8'($urandom);
		btn  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		if (pick < 55) begin
			it = {CMD_TICK, 32'($urandom)};
		end else if (pick < 88) begin
			it = make_frame(FRAME_SYNC, mode, btn);
		end else if (pick < 94) begin
			it = make_frame(FRAME_SYNC ^ flip, 8'($urandom), 8'($urandom));
		end else if (pick < 98) begin
			it = make_frame(FRAME_SYNC, mode, btn);
			it.frame_check = it.frame_check ^ flip;
		end else begin
			it = {CMD_FRAME, 32'($urandom)};
		end
		return it;
	endfunction

	// Offer one transaction after a random gap and hold it until accepted.
	task automatic send_item(input cmd_t item);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= item;
		do @(posedge clk); while (!cmd_ch.ready);
		board.note_item(item);
	endtask

	// Stop offering and wait for every expected display to come back.
	task automatic drain_results();
		cmd_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_period(input logic [7:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_period(value);
	endtask

	// Walk every button, both cursor wraps, both wraps of the seconds field and each rejection.
	task automatic run_directed();
		cmd_t bad_check;
		bad_check = make_frame(FRAME_SYNC, MODE_EDIT, BTN_UP);
		bad_check.frame_check = bad_check.frame_check ^ 8'h01;
		send_item({CMD_TICK, 32'h0000_0000});
		send_item({CMD_TICK, 32'hFFFF_FFFF});
		send_item(make_frame(FRAME_SYNC, 8'd0, BTN_UP));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, BTN_UP));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, BTN_DOWN));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, BTN_RIGHT));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, BTN_UP));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, BTN_LEFT));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, BTN_LEFT));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, BTN_DOWN));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, BTN_UP));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, BTN_RIGHT));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, 8'd4));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, 8'hFF));
		send_item(make_frame(FRAME_SYNC, 8'hFF, BTN_DOWN));
		send_item(make_frame(FRAME_SYNC, 8'd2, BTN_UP));
		send_item(make_frame(8'h00, MODE_EDIT, BTN_UP));
		send_item(make_frame(8'hFF, MODE_EDIT, BTN_UP));
		send_item(bad_check);
		send_item(make_frame(FRAME_SYNC, 8'hFF, 8'hFF));
		send_item(make_frame(FRAME_SYNC, MODE_EDIT, BTN_UP));
		send_item({CMD_FRAME, 32'hFFFF_FFFF});
		send_item({CMD_TICK, 32'($urandom)});
	endtask

	// Hold reset, then run the directed part and the random phases.
	initial begin : stimulus
		logic [7:0] periods [0:NUM_PHASES-2];
		periods[0] = 8'd2;
		periods[1] = 8'd255;
		periods[2] = 8'd1;
		periods[3] = 8'd0;
		periods[4] = 8'($urandom_range(2, 255));
		periods[5] = 8'd2;
		board = new;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 0) begin
				run_directed();
			end else begin
				drain_results();
				write_period(periods[p-1]);
			end
			no_idle = (p == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 2 && i == 40)
					hold_request = 1'b1;
				send_item(random_item());
			end
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.total_failures() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Drive result ready: random stalls, plus one long hold on request.
	initial begin : result_sink
		int stall;
		stall = 0;
		res_ch.ready = 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
			end else if (hold_request) begin
				hold_request = 1'b0;
				res_ch.ready <= 1'b0;
				stall = LONG_HOLD - 1;
			end else begin
				stall = idle_cycles();
				if (stall == 0) begin
					res_ch.ready <= 1'b1;
				end else begin
					res_ch.ready <= 1'b0;
					stall--;
				end
			end
		end
	end

	// Check every result transaction.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			board.check_result(res_ch.data);
	end

	initial begin : watchdog
		#4_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule : tb_settable_time_of_day_clock
